@@ rtl/core/sasp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sasp_pkg
// shared types and constants of the servo / soft pwm core
// ----------------------------------------------------------------------------
package sasp_pkg;

    localparam int unsigned C_DATA_W  = 8;
    localparam int unsigned C_CHAN_W  = 2;
    localparam int unsigned C_PADDR_W = 2;
    localparam int unsigned C_PDATA_W = 32;

    typedef logic [C_DATA_W-1:0] t_byte;
    typedef logic [C_CHAN_W-1:0] t_chan;

    // item kinds
    localparam logic C_KIND_TICK   = 1'b0;
    localparam logic C_KIND_SAMPLE = 1'b1;

    // adc channel codes
    localparam t_chan C_CH0 = 2'd0;
    localparam t_chan C_CH1 = 2'd1;
    localparam t_chan C_CH2 = 2'd2;
    localparam t_chan C_CH3 = 2'd3;

    // register map
    localparam logic [C_PADDR_W-1:0] C_ADDR_PERIOD = 2'd0;

    localparam t_byte C_PERIOD_RST = 8'd250;

    // floor(v*k/1000) as (v * k * ceil(2^26/1000)) >> 26, exact for 8-bit v
    localparam int unsigned C_RECIP_SHIFT = 26;
    localparam int unsigned C_PROD_W      = 32;
    localparam int unsigned C_QUOT_W      = C_PROD_W - C_RECIP_SHIFT;
    localparam logic [C_PROD_W-1:0] C_SERVO_MUL = 32'd16575923; // 247 * 67109
    localparam logic [C_PROD_W-1:0] C_SOFT_MUL  = 32'd3288341;  // 49 * 67109
    localparam t_byte C_SERVO_OFS = 8'd62;
    localparam t_byte C_SOFT_OFS  = 8'd7;

endpackage
`default_nettype wire

@@ rtl/core/sasp_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sasp_in_if
// request channel into the core: tick or adc sample
// ----------------------------------------------------------------------------
interface sasp_in_if import sasp_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  kind;
    t_byte sample;

    modport source (output valid, output kind, output sample, input ready);
    modport sink   (input valid, input kind, input sample, output ready);
endinterface
`default_nettype wire

@@ rtl/core/sasp_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sasp_out_if
// result channel out of the core: pin levels, duties, display and channel
// ----------------------------------------------------------------------------
interface sasp_out_if import sasp_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  soft_pwm_a;
    logic  soft_pwm_b;
    t_byte servo_duty_a;
    t_byte servo_duty_b;
    t_byte width_display;
    t_chan next_channel;

    modport source (
        output valid, output soft_pwm_a, output soft_pwm_b, output servo_duty_a,
        output servo_duty_b, output width_display, output next_channel, input ready
    );
    modport sink (
        input valid, input soft_pwm_a, input soft_pwm_b, input servo_duty_a,
        input servo_duty_b, input width_display, input next_channel, output ready
    );
endinterface
`default_nettype wire

@@ rtl/core/sasp_scale.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sasp_scale
// adc byte to servo duty (62..124) or soft pwm width (7..19)
// ----------------------------------------------------------------------------
module sasp_scale import sasp_pkg::*; (
    input  var t_byte i_sample,
    input  var logic  i_servo,
    output t_byte     o_value
);

    logic [C_PROD_W-1:0] w_prod;
    logic [C_QUOT_W-1:0] w_quot;

    // reciprocal multiply replaces the divide by 1000
    assign w_prod  = C_PROD_W'(i_sample) * (i_servo ? C_SERVO_MUL : C_SOFT_MUL);
    assign w_quot  = w_prod[C_PROD_W-1:C_RECIP_SHIFT];
    assign o_value = C_DATA_W'(w_quot) + (i_servo ? C_SERVO_OFS : C_SOFT_OFS);

endmodule
`default_nettype wire

@@ rtl/core/servo_adc_scan_soft_pwm_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// servo_adc_scan_soft_pwm_core
// joystick servo controller: soft pwm counter and adc channel scan
// ----------------------------------------------------------------------------
// i_in carries requests: kind 0 is a timer tick, kind 1 an adc sample for the
// channel shown on next_channel. every request gives exactly one result on
// o_out: both soft pwm pin levels, both servo duties, the second soft width
// and the channel to convert next, all as they stand after that request.
// a request is taken into an input register; when it leaves that register the
// state registers are updated and show the result. one request per cycle is
// sustained while o_out is ready; the longest path is the scaling through a
// single constant multiply.
// the result registers are the state registers themselves, so while o_out is
// stalled one more request can be taken into the input register to wait, and
// then i_in.ready drops. reset clears the counter, widths, duties and pins,
// points the scan at channel 2 and loads pwm_period with 250. pwm_period is
// written through the apb port at byte address 0; the user must write it only
// while no request is in flight, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module servo_adc_scan_soft_pwm_core import sasp_pkg::*; (
    input  var logic                 i_clk,
    input  var logic                 i_rst_n,
    sasp_in_if.sink                  i_in,
    sasp_out_if.source               o_out,
    input  var logic                 psel,
    input  var logic                 penable,
    input  var logic                 pwrite,
    input  var logic [C_PADDR_W-1:0] paddr,
    input  var logic [C_PDATA_W-1:0] pwdata,
    output logic     [C_PDATA_W-1:0] prdata,
    output logic                     pready
);

    // input register
    logic  r_in_valid;
    logic  r_in_kind;
    t_byte r_in_sample;

    // block state, also the result register
    logic  r_out_valid;
    t_byte r_pwm_period;
    t_byte r_tick;
    t_byte r_width_a;
    t_byte r_width_b;
    t_byte r_duty_a;
    t_byte r_duty_b;
    t_chan r_channel;
    logic  r_pin_a;
    logic  r_pin_b;

    t_byte n_tick;
    t_byte n_width_a;
    t_byte n_width_b;
    t_byte n_duty_a;
    t_byte n_duty_b;
    t_chan n_channel;
    logic  n_pin_a;
    logic  n_pin_b;

    logic  w_adv;
    logic  w_in_take;
    t_byte w_tick_inc;
    t_byte w_scaled;

    assign w_adv     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;
    assign w_in_take = i_in.valid && i_in.ready;

    sasp_scale u_scale (
        .i_sample (r_in_sample),
        .i_servo  (!r_channel[0]),
        .o_value  (w_scaled)
    );

    assign w_tick_inc = r_tick + 8'd1;

    always_comb begin
        n_tick    = r_tick;
        n_width_a = r_width_a;
        n_width_b = r_width_b;
        n_duty_a  = r_duty_a;
        n_duty_b  = r_duty_b;
        n_channel = r_channel;
        n_pin_a   = r_pin_a;
        n_pin_b   = r_pin_b;
        if (r_in_kind == C_KIND_TICK) begin
            n_pin_a = (w_tick_inc <= r_width_a);
            n_pin_b = (w_tick_inc <= r_width_b);
            n_tick  = (w_tick_inc >= r_pwm_period) ? '0 : w_tick_inc;
        end else begin
            unique case (r_channel)
                C_CH0: begin
                    n_duty_a  = w_scaled;
                    n_channel = C_CH2;
                end
                C_CH2: begin
                    n_duty_b  = w_scaled;
                    n_channel = C_CH3;
                end
                C_CH3: begin
                    n_width_a = w_scaled;
                    n_channel = C_CH1;
                end
                C_CH1: begin
                    n_width_b = w_scaled;
                    n_channel = C_CH0;
                end
                default: begin
                    n_channel = C_CH2;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_kind   <= i_in.kind;
            r_in_sample <= i_in.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_tick      <= '0;
            r_width_a   <= '0;
            r_width_b   <= '0;
            r_duty_a    <= '0;
            r_duty_b    <= '0;
            r_channel   <= C_CH2;
            r_pin_a     <= 1'b0;
            r_pin_b     <= 1'b0;
        end else begin
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_tick      <= n_tick;
                r_width_a   <= n_width_a;
                r_width_b   <= n_width_b;
                r_duty_a    <= n_duty_a;
                r_duty_b    <= n_duty_b;
                r_channel   <= n_channel;
                r_pin_a     <= n_pin_a;
                r_pin_b     <= n_pin_b;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period <= C_PERIOD_RST;
        end else if (psel && penable && pwrite && paddr == C_ADDR_PERIOD) begin
            r_pwm_period <= pwdata[C_DATA_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == C_ADDR_PERIOD) ? C_PDATA_W'(r_pwm_period) : '0;

    assign o_out.valid         = r_out_valid;
    assign o_out.soft_pwm_a    = r_pin_a;
    assign o_out.soft_pwm_b    = r_pin_b;
    assign o_out.servo_duty_a  = r_duty_a;
    assign o_out.servo_duty_b  = r_duty_b;
    assign o_out.width_display = r_width_b;
    assign o_out.next_channel  = r_channel;

    // samples walk the scan order 2, 3, 1, 0
    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_in_kind == C_KIND_SAMPLE |=>
            (($past(r_channel) == C_CH2 && r_channel == C_CH3) ||
             ($past(r_channel) == C_CH3 && r_channel == C_CH1) ||
             ($past(r_channel) == C_CH1 && r_channel == C_CH0) ||
             ($past(r_channel) == C_CH0 && r_channel == C_CH2)))
        else $error("adc channel scan out of order");

    // a sample never moves the pins or the counter
    a_sample_keeps_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_in_kind == C_KIND_SAMPLE |=>
            $stable(r_pin_a) && $stable(r_pin_b) && $stable(r_tick))
        else $error("sample changed soft pwm state");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_duty_a == '0 || (r_duty_a >= 8'd62 && r_duty_a <= 8'd124)) &&
        (r_duty_b == '0 || (r_duty_b >= 8'd62 && r_duty_b <= 8'd124)))
        else $error("servo duty out of range");

    a_width_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_width_a == '0 || (r_width_a >= 8'd7 && r_width_a <= 8'd19)) &&
        (r_width_b == '0 || (r_width_b >= 8'd7 && r_width_b <= 8'd19)))
        else $error("soft pwm width out of range");

endmodule
`default_nettype wire
